// ===== design/kst_pkg.sv =====
// Shared codes, key state encodings and the result struct of the key state tracker.
package kst_pkg;

    // Two-bit key states held in the table.
    localparam logic [1:0] KS_NONE     = 2'd0;
    localparam logic [1:0] KS_UP       = 2'd1;
    localparam logic [1:0] KS_DOWN     = 2'd2;
    localparam logic [1:0] KS_RELEASED = 2'd3;

    // Commands.
    localparam logic [1:0] CMD_EVENT = 2'd0;
    localparam logic [1:0] CMD_SWEEP = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Renumbered message kinds.
    localparam logic [3:0] EK_KEYDOWN = 4'd0;
    localparam logic [3:0] EK_KEYUP   = 4'd1;
    localparam logic [3:0] EK_LDOWN   = 4'd2;
    localparam logic [3:0] EK_LUP     = 4'd3;
    localparam logic [3:0] EK_LDBL    = 4'd4;
    localparam logic [3:0] EK_RDOWN   = 4'd5;
    localparam logic [3:0] EK_RUP     = 4'd6;
    localparam logic [3:0] EK_RDBL    = 4'd7;
    localparam logic [3:0] EK_MDOWN   = 4'd8;
    localparam logic [3:0] EK_MUP     = 4'd9;
    localparam logic [3:0] EK_MDBL    = 4'd10;
    localparam logic [3:0] EK_XDOWN   = 4'd11;
    localparam logic [3:0] EK_XUP     = 4'd12;
    localparam logic [3:0] EK_XDBL    = 4'd13;

    // Bind modes.
    localparam logic [1:0] BM_HOLD   = 2'd0;
    localparam logic [1:0] BM_TOGGLE = 2'd1;

    // Fixed table indices of the mouse buttons.
    localparam logic [2:0] IDX_LEFT    = 3'd1;
    localparam logic [2:0] IDX_RIGHT   = 3'd2;
    localparam logic [2:0] IDX_MIDDLE  = 3'd4;
    localparam logic [2:0] IDX_XFIRST  = 3'd5;
    localparam logic [2:0] IDX_XSECOND = 3'd6;

    // X button selector value that picks the first button.
    localparam logic [15:0] XSEL_FIRST = 16'd1;

    typedef struct packed {
        logic valid;
        logic handled;
        logic bind_enable;
    } t_result;

endpackage

// ===== design/kst_mem.sv =====
// Key state table: one write port and one read port with registered read data.
module kst_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/kst_seq.sv =====
// Sequencer: clearing pass, event read-modify-write, frame sweep and bind query.
module kst_seq #(
    parameter int NUM_KEYS = 256,
    parameter int AW       = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_busy,
    input  logic [1:0]      i_command,
    input  logic [3:0]      i_event_kind,
    input  logic [15:0]     i_key_code,
    input  logic [7:0]      i_bind_key,
    input  logic [1:0]      i_bind_mode,
    input  logic            i_bind_enable_in,
    input  logic            i_out_free,
    output kst_pkg::t_result o_res,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output logic [1:0]      o_wdata,
    output logic            o_re,
    output logic [AW-1:0]   o_raddr,
    input  logic [1:0]      i_rdata
);

    import kst_pkg::*;

    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_KEYS - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(NUM_KEYS);
    localparam logic [16:0]   CODE_LIM = 17'(NUM_KEYS);
    localparam logic [8:0]    BKEY_LIM = 9'(NUM_KEYS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVT   = 3'd2;
    localparam logic [2:0] S_QRY   = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_paddr, n_paddr;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_is_up, n_is_up;
    logic [1:0]    r_mode, n_mode;
    logic          r_en_in, n_en_in;
    logic          r_handled, n_handled;
    logic          r_en_out, n_en_out;

    logic          ev_ok;
    logic          ev_up;
    logic          ev_handled;
    logic [AW-1:0] ev_idx;
    logic          code_ok;
    logic          bkey_ok;
    logic          sweep_rd;

    assign code_ok = {1'b0, i_key_code} < CODE_LIM;
    assign bkey_ok = {1'b0, i_bind_key} < BKEY_LIM;

    // Map a message kind to a table index and a down/up action.
    always_comb begin
        ev_ok      = 1'b1;
        ev_up      = 1'b0;
        ev_handled = 1'b1;
        ev_idx     = i_key_code[AW-1:0];
        case (i_event_kind)
            EK_KEYDOWN: begin
                ev_ok = code_ok;
            end
            EK_KEYUP: begin
                ev_ok = code_ok;
                ev_up = 1'b1;
            end
            EK_LDOWN, EK_LDBL: begin
                ev_idx = AW'(IDX_LEFT);
            end
            EK_LUP: begin
                ev_idx = AW'(IDX_LEFT);
                ev_up  = 1'b1;
            end
            EK_RDOWN, EK_RDBL: begin
                ev_idx = AW'(IDX_RIGHT);
            end
            EK_RUP: begin
                ev_idx = AW'(IDX_RIGHT);
                ev_up  = 1'b1;
            end
            EK_MDOWN, EK_MDBL: begin
                ev_idx = AW'(IDX_MIDDLE);
            end
            EK_MUP: begin
                ev_idx = AW'(IDX_MIDDLE);
                ev_up  = 1'b1;
            end
            EK_XDOWN, EK_XUP, EK_XDBL: begin
                ev_idx = (i_key_code == XSEL_FIRST) ? AW'(IDX_XFIRST) : AW'(IDX_XSECOND);
                ev_up  = (i_event_kind == EK_XUP);
            end
            default: begin
                ev_ok      = 1'b0;
                ev_handled = 1'b0;
            end
        endcase
    end

    assign sweep_rd = (r_cnt != CNT_FULL);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pend    = 1'b0;
        n_paddr   = r_paddr;
        n_addr    = r_addr;
        n_is_up   = r_is_up;
        n_mode    = r_mode;
        n_en_in   = r_en_in;
        n_handled = r_handled;
        n_en_out  = r_en_out;
        o_re      = 1'b0;
        o_raddr   = r_cnt[AW-1:0];
        o_we      = 1'b0;
        o_waddr   = r_addr;
        o_wdata   = KS_NONE;
        o_res     = '0;
        case (r_state)
            S_INIT: begin
                o_we    = 1'b1;
                o_waddr = r_cnt[AW-1:0];
                o_wdata = KS_NONE;
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_handled = 1'b0;
                    n_en_out  = 1'b0;
                    n_is_up   = ev_up;
                    n_mode    = i_bind_mode;
                    n_en_in   = i_bind_enable_in;
                    n_state   = S_DONE;
                    case (i_command)
                        CMD_EVENT: begin
                            n_handled = ev_handled;
                            if (ev_ok) begin
                                o_re    = 1'b1;
                                o_raddr = ev_idx;
                                n_addr  = ev_idx;
                                n_state = S_EVT;
                            end
                        end
                        CMD_SWEEP: begin
                            n_cnt   = '0;
                            n_state = S_SWEEP;
                        end
                        CMD_QUERY: begin
                            if (i_bind_key != 8'd0) begin
                                if (bkey_ok) begin
                                    o_re    = 1'b1;
                                    o_raddr = i_bind_key[AW-1:0];
                                    n_state = S_QRY;
                                end else begin
                                    // A key outside the table reads as state none.
                                    n_en_out = (i_bind_mode == BM_HOLD) ? 1'b0
                                                                        : i_bind_enable_in;
                                end
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_EVT: begin
                o_we    = 1'b1;
                o_waddr = r_addr;
                if (r_is_up) begin
                    o_wdata = (i_rdata == KS_DOWN) ? KS_RELEASED : KS_UP;
                end else begin
                    o_wdata = KS_DOWN;
                end
                n_state = S_DONE;
            end
            S_QRY: begin
                if (r_mode == BM_HOLD) begin
                    n_en_out = (i_rdata == KS_DOWN);
                end else if (r_mode == BM_TOGGLE && i_rdata == KS_RELEASED) begin
                    n_en_out = ~r_en_in;
                end else begin
                    n_en_out = r_en_in;
                end
                n_state = S_DONE;
            end
            S_SWEEP: begin
                // Read entry i while entry i-1 is written back, so no entry is
                // read and written in the same cycle.
                o_re    = sweep_rd;
                o_raddr = r_cnt[AW-1:0];
                n_pend  = sweep_rd;
                n_paddr = r_cnt[AW-1:0];
                if (sweep_rd) begin
                    n_cnt = r_cnt + CW'(1);
                end
                o_we    = r_pend && (i_rdata == KS_RELEASED);
                o_waddr = r_paddr;
                o_wdata = KS_UP;
                if (!sweep_rd && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res.valid       = i_out_free;
                o_res.handled     = r_handled;
                o_res.bind_enable = r_en_out;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr   <= n_paddr;
        r_addr    <= n_addr;
        r_is_up   <= n_is_up;
        r_mode    <= n_mode;
        r_en_in   <= n_en_in;
        r_handled <= n_handled;
        r_en_out  <= n_en_out;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/key_state_tracker_with_binds.sv =====
// Top level of the key state tracker: table, sequencer and output register.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-----------------------------------------------
//   in      | i_valid | o_stall | i_command, i_event_kind, i_key_code,
//           |         |         | i_bind_key, i_bind_mode, i_bind_enable_in
//   out     | o_valid | i_stall | o_handled, o_bind_enable_out
//
// An event or a query that reads the table passes a write-back or compute state and
// then the hand-off state before o_valid; one that touches no entry goes straight to
// the hand-off state. A frame sweep walks the table one entry per cycle. After reset
// a clearing pass writes every entry to none, with o_stall high. A held result waits
// in the output register; the next item is accepted once the sequencer is idle again.
module key_state_tracker_with_binds #(
    parameter int NUM_KEYS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_event_kind,
    input  logic [15:0] i_key_code,
    input  logic [7:0]  i_bind_key,
    input  logic [1:0]  i_bind_mode,
    input  logic        i_bind_enable_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_handled,
    output logic        o_bind_enable_out
);

    import kst_pkg::*;

    localparam int AW = $clog2(NUM_KEYS);

    logic          busy;
    logic          out_free;
    t_result       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [1:0]    mem_rdata;

    logic r_o_valid;
    logic r_o_handled;
    logic r_o_en;

    assign out_free = !r_o_valid || !i_stall;

    kst_seq #(
        .NUM_KEYS (NUM_KEYS),
        .AW       (AW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_busy           (busy),
        .i_command        (i_command),
        .i_event_kind     (i_event_kind),
        .i_key_code       (i_key_code),
        .i_bind_key       (i_bind_key),
        .i_bind_mode      (i_bind_mode),
        .i_bind_enable_in (i_bind_enable_in),
        .i_out_free       (out_free),
        .o_res            (res),
        .o_we             (mem_we),
        .o_waddr          (mem_waddr),
        .o_wdata          (mem_wdata),
        .o_re             (mem_re),
        .o_raddr          (mem_raddr),
        .i_rdata          (mem_rdata)
    );

    kst_mem #(
        .DEPTH (NUM_KEYS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res.valid) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_o_handled <= res.handled;
            r_o_en      <= res.bind_enable;
        end
    end

    assign o_stall           = busy;
    assign o_valid           = r_o_valid;
    assign o_handled         = r_o_handled;
    assign o_bind_enable_out = r_o_en;

`ifndef SYNTHESIS
    // An accepted item makes the sequencer busy, which raises o_stall.
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item accepted right after the first");

    // A result from the sequencer always lands in the output register.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |=> r_o_valid)
        else $error("result lost on the way to the output register");

    // A result is either an event answer or a query answer, never both.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_handled && o_bind_enable_out))
        else $error("handled and bind enable both set");

    // The sequencer never hands over a result while it is idle.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> o_stall)
        else $error("result produced while idle");
`endif

endmodule
